@@ src/rdc_pkg.sv @@
// Shared constants and controller/datapath interface types for the radix digit converter.
package rdc_pkg;

   localparam int STACK_DEPTH_DEF = 32;
   localparam int VALUE_WIDTH_DEF = 32;

   localparam int DIGIT_W  = 4;
   localparam int RADIX_W  = 5;
   localparam int DIV_BITS = 8;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd8;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_RADIX_IDX = 1'b0;

   typedef struct packed {
      logic load;
      logic div_step;
      logic pop_rd;
      logic out_load;
   } rdc_cmd_type;

   typedef struct packed {
      logic div_last;
      logic more_digits;
      logic top_zero;
      logic out_free;
   } rdc_status_type;

endpackage

@@ src/rdc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rdc_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/rdc_dpath.sv @@
// Datapath: radix divider, digit stack and result register.
module rdc_dpath import rdc_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rdc_cmd_type            cmd,
   output rdc_status_type         status,
   input  logic [RADIX_W-1:0]     radix,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [DIGIT_W-1:0]     rsp_digit,
   output logic                   rsp_last_digit
);

   localparam int PAD_W  = ((VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
   localparam int STEPS  = PAD_W / DIV_BITS;
   localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int TOP_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   logic [PAD_W-1:0]    num_ff, num_in;
   logic [DIGIT_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0]   step_ff;
   logic [TOP_W-1:0]    top_ff, top_dec;
   logic                rsp_valid_ff;
   logic [DIGIT_W-1:0]  rsp_digit_ff;
   logic                rsp_last_ff;
   logic [RADIX_W-1:0]  base;
   logic [DIV_BITS-1:0] qbits;
   logic [RADIX_W-1:0]  part;
   logic                div_last;
   logic [DIGIT_W-1:0]  ram_rd_data;

   always_comb begin
      if (radix < RADIX_MIN) begin
         base = RADIX_MIN;
      end else if (radix > RADIX_MAX) begin
         base = RADIX_MAX;
      end else begin
         base = radix;
      end
   end

   // Restoring division, DIV_BITS dividend bits per cycle on a narrow remainder.
   always_comb begin
      part  = {1'b0, rem_ff};
      qbits = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         part = {part[RADIX_W-2:0], num_ff[PAD_W-1-i]};
         if (part >= base) begin
            part = part - base;
            qbits[DIV_BITS-1-i] = 1'b1;
         end
      end
      num_in = (num_ff << DIV_BITS) | PAD_W'(qbits);
      rem_in = part[DIGIT_W-1:0];
   end

   assign div_last = (step_ff == STEP_W'(STEPS - 1));
   assign top_dec  = top_ff - TOP_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            step_ff <= '0;
            top_ff  <= '0;
         end else if (cmd.div_step) begin
            step_ff <= div_last ? '0 : step_ff + STEP_W'(1);
            if (div_last) begin
               top_ff <= top_ff + TOP_W'(1);
            end
         end else if (cmd.pop_rd) begin
            top_ff <= top_dec;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         num_ff <= PAD_W'(req_value);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         num_ff <= num_in;
         // start each digit's division with a clear remainder
         rem_ff <= div_last ? '0 : rem_in;
      end
      if (cmd.out_load) begin
         rsp_digit_ff <= ram_rd_data;
         rsp_last_ff  <= (top_ff == '0);
      end
   end

   rdc_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (cmd.div_step && div_last),
      .wr_addr (top_ff[ADDR_W-1:0]),
      .wr_data (rem_in),
      .rd_en   (cmd.pop_rd),
      .rd_addr (top_dec[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign status.div_last    = div_last;
   assign status.more_digits = (num_in != '0) && (top_ff < TOP_W'(STACK_DEPTH - 1));
   assign status.top_zero    = (top_ff == '0);
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit      = rsp_digit_ff;
   assign rsp_last_digit = rsp_last_ff;

endmodule

@@ src/rdc_ctrl.sv @@
// Controller: sequences load, division per digit, and stack pop per result.
module rdc_ctrl import rdc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  rdc_status_type status,
   output rdc_cmd_type    cmd
);

   typedef enum logic [1:0] {
      IDLE,
      DIV,
      POP_RD,
      POP_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.load = 1'b1;
               state_in = DIV;
            end
         end
         DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last && !status.more_digits) begin
               state_in = POP_RD;
            end
         end
         POP_RD: begin
            cmd.pop_rd = 1'b1;
            state_in   = POP_WAIT;
         end
         POP_WAIT: begin
            // hold the popped digit until the result register frees up
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = status.top_zero ? IDLE : POP_RD;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == IDLE);
      end
   end

   assign req_ready = ready_ff;

   a_accept_starts_div: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == DIV)
      else $error("accepted transfer did not start division");

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == IDLE)
      else $error("ready raised outside idle");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result register overwritten");

   a_pop_then_wait: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_rd |=> state_ff == POP_WAIT)
      else $error("stack read not followed by result wait");

   a_last_goes_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load && status.top_zero |=> req_ready)
      else $error("final digit did not return to idle");

endmodule

@@ src/radix_digit_converter.sv @@
// Radix digit converter top level: CSR port, controller and datapath.
// A load, then a shared-divider pass per digit (8 quotient bits a cycle), then it
// pops each digit from the stack RAM into the result register once that is free.
// A 32-bit octal value needs up to 11 digits. One item is worked at a time.
// Reset (synchronous, active high) empties the stack, drops any pending result
// and sets the radix to 8.
module radix_digit_converter import rdc_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [DIGIT_W-1:0]     rsp_digit,
   output logic                   rsp_last_digit,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   logic [RADIX_W-1:0] radix_ff;
   rdc_cmd_type        cmd;
   rdc_status_type     status;
   logic               csr_hit;

   assign pready  = 1'b1;
   assign csr_hit = (paddr[CSR_ADDR_W-1] == CSR_RADIX_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (psel && penable && pwrite && pready && csr_hit) begin
         radix_ff <= pwdata[RADIX_W-1:0];
      end
   end

   assign prdata = csr_hit ? CSR_DATA_W'(radix_ff) : '0;

   rdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rdc_dpath #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .radix          (radix_ff),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit      (rsp_digit),
      .rsp_last_digit (rsp_last_digit)
   );

endmodule
